// ----- src/ltdr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ltdr_pkg
// shared types and constants of the text lcd delta refresh block
// ----------------------------------------------------------------------------
package ltdr_pkg;

    typedef enum logic [2:0] {
        CMD_CELL       = 3'd0,
        CMD_SET_CURSOR = 3'd1,
        CMD_CLEAR_HOME = 3'd2,
        CMD_BLANK      = 3'd3,
        CMD_DISP_CTRL  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_DISPLAY_ON   = 2'd0,
        CFG_CURSOR_SHOWN = 2'd1,
        CFG_CURSOR_BLINK = 2'd2
    } t_cfg_reg;

    // controller instruction bytes
    localparam logic [7:0] LCD_SET_ADDR = 8'h80;
    localparam logic [7:0] LCD_CLEAR    = 8'h01;
    localparam logic [7:0] LCD_CTRL     = 8'h08;
    localparam logic [7:0] LCD_CTRL_CUR = 8'h02;
    localparam logic [7:0] LCD_CTRL_ON  = 8'h04;
    localparam logic [7:0] LCD_SPACE    = 8'h20;
    localparam logic [6:0] ODD_ROW_BASE = 7'h40;

    localparam int MAX_RESULTS = 4;

endpackage : ltdr_pkg
`default_nettype wire

// ----- src/ltdr_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ltdr_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ltdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 80
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule : ltdr_ram
`default_nettype wire

// ----- src/lcd_text_delta_refresh.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_text_delta_refresh
// turns streamed text frames into minimal character lcd bus writes
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  ----------+-----------+----------------------------------------------------
//  s_axis    | in        | tuser: cmd, tdata: char_code, cursor_col,
//            |           |        cursor_row, force_cursor_addr
//  m_axis    | out       | tuser: is_data, tdata: bus_byte, tlast: run_last
//  cfg       | in        | write only: display_on, cursor_shown, cursor_blink
//
//  an input transaction enters the input register and the shadow ram read is
//  registered at the same edge; once the result buffer is empty or about to be,
//  the held item builds up to four bus writes at once into the result buffer
//  the result buffer drains one transaction per cycle while the output is
//  ready, so an item with k results holds the output until all k are taken;
//  items with no result leave the output idle; a new item is taken while results still drain
//  the shadow is reset by one valid flop per cell, so no clearing pass
//  reset is synchronous, active low; output stalls back up into the input
// ----------------------------------------------------------------------------
module lcd_text_delta_refresh #(
    parameter int COLUMNS = 20,
    parameter int ROWS    = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [2:0]  i_s_axis_tuser,   // cmd
    input  wire logic [15:0] i_s_axis_tdata,   // char_code[7:0], cursor_col[12:8],
                                               // cursor_row[14:13], force_cursor_addr[15]
    // output stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [0:0]       o_m_axis_tuser,   // is_data
    output logic [7:0]       o_m_axis_tdata,   // bus_byte
    output logic             o_m_axis_tlast,
    // configuration writes
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [0:0]  i_cfg_wdata
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int POS_W = $clog2(CELLS);
    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(CELLS - 1);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
    localparam logic [7:0]       COLS_B   = 8'(COLUMNS);
    localparam logic [2:0]       ROWS_B   = 3'(ROWS);

    // display address of a cell: odd rows sit at 0x40, lower half one row on
    function automatic logic [6:0] addr_of(input logic [7:0] col, input logic [1:0] row);
        logic [7:0] a;
        a = col;
        if (row[0]) begin
            a = a + {1'b0, ltdr_pkg::ODD_ROW_BASE};
        end
        if (row[1]) begin
            a = a + COLS_B;
        end
        return a[6:0];
    endfunction

    // configuration registers
    logic r_display_on;
    logic r_cursor_shown;
    logic r_cursor_blink;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_on   <= 1'b0;
            r_cursor_shown <= 1'b0;
            r_cursor_blink <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ltdr_pkg::CFG_DISPLAY_ON:   r_display_on   <= i_cfg_wdata[0];
                ltdr_pkg::CFG_CURSOR_SHOWN: r_cursor_shown <= i_cfg_wdata[0];
                ltdr_pkg::CFG_CURSOR_BLINK: r_cursor_blink <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // handshake control
    logic       r_in_valid;
    logic [2:0] r_res_cnt;
    logic       in_fire;
    logic       out_pop;
    logic       proc_fire;

    assign out_pop   = o_m_axis_tvalid && i_m_axis_tready;
    // the result buffer takes a new batch once it is empty or about to be
    assign proc_fire = r_in_valid && ((r_res_cnt == 3'd0) || ((r_res_cnt == 3'd1) && out_pop));
    assign o_s_axis_tready = !r_in_valid || proc_fire;
    assign in_fire = i_s_axis_tvalid && o_s_axis_tready;

    // frame scan position, advanced when a cell transaction is taken
    logic [POS_W-1:0] r_pos;
    logic [COL_W-1:0] r_pcol;
    logic [ROW_W-1:0] r_prow;
    logic             in_is_cell;

    assign in_is_cell = (i_s_axis_tuser == ltdr_pkg::CMD_CELL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_pcol <= '0;
            r_prow <= '0;
        end else if (in_fire && in_is_cell) begin
            if (r_pos == LAST_POS) begin
                r_pos  <= '0;
                r_pcol <= '0;
                r_prow <= '0;
            end else begin
                r_pos <= r_pos + POS_W'(1);
                if (r_pcol == LAST_COL) begin
                    r_pcol <= '0;
                    r_prow <= (r_prow == LAST_ROW) ? '0 : r_prow + ROW_W'(1);
                end else begin
                    r_pcol <= r_pcol + COL_W'(1);
                end
            end
        end
    end

    // input register
    logic [2:0]       r_in_cmd;
    logic [7:0]       r_in_char;
    logic [4:0]       r_in_ccol;
    logic [1:0]       r_in_crow;
    logic             r_in_force;
    logic [POS_W-1:0] r_in_pos;
    logic [COL_W-1:0] r_in_col;
    logic [ROW_W-1:0] r_in_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_cmd   <= i_s_axis_tuser;
            r_in_char  <= i_s_axis_tdata[7:0];
            r_in_ccol  <= i_s_axis_tdata[12:8];
            r_in_crow  <= i_s_axis_tdata[14:13];
            r_in_force <= i_s_axis_tdata[15];
            r_in_pos   <= r_pos;
            r_in_col   <= r_pcol;
            r_in_row   <= r_prow;
        end
    end

    // shadow screen: ram for the characters, one valid flop per cell
    // an invalid cell reads as a space
    logic [CELLS-1:0] r_valid;
    logic [7:0]       shadow_q;
    logic             shadow_we;

    ltdr_ram #(
        .WIDTH (8),
        .DEPTH (CELLS)
    ) u_shadow (
        .i_clk   (i_clk),
        .i_we    (shadow_we),
        .i_waddr (r_in_pos),
        .i_wdata (r_in_char),
        .i_re    (in_fire),
        .i_raddr (r_pos),
        .o_rdata (shadow_q)
    );

    // display state
    logic [6:0] r_disp_addr;
    logic [6:0] r_run_addr;
    logic [6:0] r_saved_addr;
    logic [2:0] r_applied;

    logic [6:0] n_disp_addr;
    logic [6:0] n_run_addr;
    logic [6:0] n_saved_addr;
    logic [2:0] n_applied;
    logic       clear_shadow;

    logic [7:0] e_byte [ltdr_pkg::MAX_RESULTS];
    logic [3:0] e_data;
    logic [2:0] e_cnt;

    logic [7:0] hide_b;
    logic [7:0] restore_b;
    logic [2:0] ctrl_bits;

    assign hide_b    = ltdr_pkg::LCD_CTRL | (r_display_on ? ltdr_pkg::LCD_CTRL_ON : 8'h00);
    assign restore_b = hide_b | ltdr_pkg::LCD_CTRL_CUR | {7'd0, r_cursor_blink};
    assign ctrl_bits = {r_display_on, r_cursor_shown, r_cursor_blink};

    always_comb begin
        logic [7:0] old_char;
        logic [6:0] cell_addr;
        logic [6:0] run;
        logic [6:0] saved;
        logic [7:0] fcol;
        logic [2:0] frow;
        logic       first;
        logic       last;

        n_disp_addr  = r_disp_addr;
        n_run_addr   = r_run_addr;
        n_saved_addr = r_saved_addr;
        n_applied    = r_applied;
        clear_shadow = 1'b0;
        shadow_we    = 1'b0;
        e_cnt        = 3'd0;
        e_data       = '0;
        for (int k = 0; k < ltdr_pkg::MAX_RESULTS; k++) begin
            e_byte[k] = 8'h00;
        end

        old_char  = r_valid[r_in_pos] ? shadow_q : ltdr_pkg::LCD_SPACE;
        cell_addr = addr_of(8'(r_in_col), 2'(r_in_row));
        first     = (r_in_pos == '0);
        last      = (r_in_pos == LAST_POS);
        run       = first ? r_disp_addr : r_run_addr;
        saved     = first ? r_disp_addr : r_saved_addr;

        // forced cursor wraps into range
        fcol = {3'd0, r_in_ccol};
        frow = {1'b0, r_in_crow};
        for (int k = 0; k < 4; k++) begin
            if (fcol >= COLS_B) begin
                fcol = fcol - COLS_B;
            end
            if (frow >= ROWS_B) begin
                frow = frow - ROWS_B;
            end
        end

        case (r_in_cmd)
            ltdr_pkg::CMD_CELL: begin
                shadow_we    = proc_fire;
                n_saved_addr = saved;
                if (first && r_cursor_shown) begin
                    e_byte[e_cnt[1:0]] = hide_b;
                    e_cnt = e_cnt + 3'd1;
                end
                if (r_in_char != old_char) begin
                    if (cell_addr != run) begin
                        e_byte[e_cnt[1:0]] = ltdr_pkg::LCD_SET_ADDR | {1'b0, cell_addr};
                        e_cnt = e_cnt + 3'd1;
                    end
                    e_byte[e_cnt[1:0]] = r_in_char;
                    e_data[e_cnt[1:0]] = 1'b1;
                    e_cnt = e_cnt + 3'd1;
                    run = cell_addr + 7'd1;
                end
                n_run_addr = run;
                if (last) begin
                    if (r_in_force) begin
                        n_disp_addr = addr_of(fcol, frow[1:0]);
                        e_byte[e_cnt[1:0]] = ltdr_pkg::LCD_SET_ADDR | {1'b0, n_disp_addr};
                        e_cnt = e_cnt + 3'd1;
                    end else if (run != saved) begin
                        e_byte[e_cnt[1:0]] = ltdr_pkg::LCD_SET_ADDR | {1'b0, saved};
                        e_cnt = e_cnt + 3'd1;
                    end
                    if (r_cursor_shown) begin
                        e_byte[e_cnt[1:0]] = restore_b;
                        e_cnt = e_cnt + 3'd1;
                    end
                end
            end
            ltdr_pkg::CMD_SET_CURSOR: begin
                if (({3'd0, r_in_ccol} < COLS_B) && ({1'b0, r_in_crow} < ROWS_B)) begin
                    n_disp_addr = addr_of({3'd0, r_in_ccol}, r_in_crow);
                    e_byte[0] = ltdr_pkg::LCD_SET_ADDR | {1'b0, n_disp_addr};
                    e_cnt = 3'd1;
                end
            end
            ltdr_pkg::CMD_CLEAR_HOME: begin
                clear_shadow = 1'b1;
                n_disp_addr  = 7'd0;
                e_byte[0]    = ltdr_pkg::LCD_CLEAR;
                e_cnt        = 3'd1;
            end
            ltdr_pkg::CMD_BLANK: begin
                clear_shadow = 1'b1;
                if (r_cursor_shown) begin
                    e_byte[e_cnt[1:0]] = hide_b;
                    e_cnt = e_cnt + 3'd1;
                end
                e_byte[e_cnt[1:0]] = ltdr_pkg::LCD_CLEAR;
                e_cnt = e_cnt + 3'd1;
                if (r_disp_addr != 7'd0) begin
                    e_byte[e_cnt[1:0]] = ltdr_pkg::LCD_SET_ADDR | {1'b0, r_disp_addr};
                    e_cnt = e_cnt + 3'd1;
                end
                if (r_cursor_shown) begin
                    e_byte[e_cnt[1:0]] = restore_b;
                    e_cnt = e_cnt + 3'd1;
                end
            end
            ltdr_pkg::CMD_DISP_CTRL: begin
                if (ctrl_bits != r_applied) begin
                    n_applied = ctrl_bits;
                    e_byte[0] = ltdr_pkg::LCD_CTRL | {5'd0, ctrl_bits};
                    e_cnt     = 3'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disp_addr  <= '0;
            r_run_addr   <= '0;
            r_saved_addr <= '0;
            r_applied    <= '0;
            r_valid      <= '0;
        end else if (proc_fire) begin
            r_disp_addr  <= n_disp_addr;
            r_run_addr   <= n_run_addr;
            r_saved_addr <= n_saved_addr;
            r_applied    <= n_applied;
            if (clear_shadow) begin
                r_valid <= '0;
            end else if (shadow_we) begin
                r_valid[r_in_pos] <= 1'b1;
            end
        end
    end

    // result buffer, drained from entry zero one transaction per cycle while the output is ready
    logic [7:0] r_res_byte [ltdr_pkg::MAX_RESULTS];
    logic [3:0] r_res_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_cnt <= 3'd0;
        end else if (proc_fire) begin
            r_res_cnt <= e_cnt;
        end else if (out_pop) begin
            r_res_cnt <= r_res_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire) begin
            r_res_byte <= e_byte;
            r_res_data <= e_data;
        end else if (out_pop) begin
            for (int k = 0; k < ltdr_pkg::MAX_RESULTS - 1; k++) begin
                r_res_byte[k] <= r_res_byte[k+1];
            end
            r_res_data <= {1'b0, r_res_data[3:1]};
        end
    end

    assign o_m_axis_tvalid   = (r_res_cnt != 3'd0);
    assign o_m_axis_tdata    = r_res_byte[0];
    assign o_m_axis_tuser[0] = r_res_data[0];
    assign o_m_axis_tlast    = (r_res_cnt == 3'd1);

    // checks
    a_res_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_cnt <= 3'(ltdr_pkg::MAX_RESULTS))
        else $error("result count above buffer depth");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= LAST_POS)
        else $error("scan position out of frame");

    a_pos_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos == '0) |-> ((r_pcol == '0) && (r_prow == '0)))
        else $error("scan column or row out of step with position");

    a_clear_shadow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_fire && (r_in_cmd == ltdr_pkg::CMD_CLEAR_HOME)) |=> (r_valid == '0))
        else $error("shadow not cleared after clear home");

endmodule : lcd_text_delta_refresh
`default_nettype wire
